@@ src/ird_pkg.sv @@
// Shared types and constants of the input-restricted deque.
package ird_pkg;

	localparam int CMD_W  = 2;
	localparam int DATA_W = 32;
	localparam int STAT_W = 3;
	localparam int POS_W  = 7;

	localparam logic [CMD_W-1:0] CMD_INSERT       = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_REAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH       = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

	// Source of the removed_value field of a result.
	typedef enum logic [1:0] {
		RM_ZERO,
		RM_ONES,
		RM_DATA
	} rm_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                latch;
		logic                ins;
		logic                rd_end;
		logic                pop;
		logic                scan_start;
		logic                scan_step;
		logic                res_load;
		logic [STAT_W-1:0]   res_status;
		rm_sel_t             res_removed;
		logic                res_pos;
		logic                out_load;
	} ird_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             full;
		logic             last;
		logic             match;
	} ird_stat_t;

endpackage

@@ src/ird_req_if.sv @@
// Request channel: one command and its value per item.
interface ird_req_if import ird_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

@@ src/ird_rsp_if.sv @@
// Response channel: one result per item.
interface ird_rsp_if import ird_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] removed_value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output status, output removed_value, output position,
		input ready);
	modport sink (input valid, input status, input removed_value, input position,
		output ready);
endinterface

@@ src/ird_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ird_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ src/ird_dp.sv @@
// Datapath of the deque: pointers, slot memory, scan pointer and result registers.
module ird_dp import ird_pkg::*; #(
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ird_ctl_t                 ctl,
	output ird_stat_t                st,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	output logic [STAT_W-1:0]        status,
	output logic signed [DATA_W-1:0] removed_value,
	output logic [POS_W-1:0]         position
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic              empty_q;
	logic [AW-1:0]     ptr_q;
	logic [STAT_W-1:0] res_status_q;
	logic [DATA_W-1:0] res_removed_q;
	logic [POS_W-1:0]  res_pos_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] removed_q;
	logic [POS_W-1:0]  position_q;

	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] removed_nxt;

	assign waddr = empty_q ? '0 : tail_q + AW'(1);

	always_comb begin
		raddr = head_q;
		if (ctl.scan_step) begin
			raddr = ptr_q + AW'(1);
		end else if (ctl.rd_end && cmd_q == CMD_REMOVE_REAR) begin
			raddr = tail_q;
		end
	end

	ird_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.we      (ctl.ins),
		.waddr   (waddr),
		.wdata   (val_q),
		.raddr   (raddr),
		.rdata_q (rdata_q)
	);

	assign st.cmd   = cmd_q;
	assign st.empty = empty_q;
	assign st.full  = (tail_q == LAST);
	assign st.last  = (ptr_q == tail_q);
	assign st.match = (rdata_q == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (ctl.ins) begin
			if (empty_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b0;
			end else begin
				tail_q <= tail_q + AW'(1);
			end
		end else if (ctl.pop) begin
			if (head_q != tail_q) begin
				if (cmd_q == CMD_REMOVE_REAR) begin
					tail_q <= tail_q - AW'(1);
				end else begin
					head_q <= head_q + AW'(1);
				end
			end else begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end
		end
	end

	always_comb begin
		case (ctl.res_removed)
			RM_DATA: removed_nxt = rdata_q;
			RM_ONES: removed_nxt = '1;
			default: removed_nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= command;
			val_q <= value;
		end
		if (ctl.scan_start) begin
			ptr_q <= head_q;
		end else if (ctl.scan_step) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (ctl.res_load) begin
			res_status_q  <= ctl.res_status;
			res_removed_q <= removed_nxt;
			res_pos_q     <= ctl.res_pos ? POS_W'(ptr_q) : '0;
		end
		if (ctl.out_load) begin
			status_q   <= res_status_q;
			removed_q  <= res_removed_q;
			position_q <= res_pos_q;
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign position      = position_q;

endmodule

@@ src/ird_ctrl.sv @@
// Controller of the deque: sequences each command and owns the output valid flag.
module ird_ctrl import ird_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ird_stat_t st,
	output ird_ctl_t  ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl             = '0;
		ctl.res_removed = RM_ZERO;
		ctl.res_status  = ST_DONE;
		state_nxt       = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.res_load = 1'b1;
				state_nxt    = S_EMIT;
				case (st.cmd) inside
					CMD_INSERT: begin
						if (!st.empty && st.full) begin
							ctl.res_status = ST_OVERFLOW;
						end else begin
							ctl.ins = 1'b1;
						end
					end
					CMD_REMOVE_FRONT, CMD_REMOVE_REAR: begin
						if (st.empty) begin
							ctl.res_status  = ST_UNDERFLOW;
							ctl.res_removed = RM_ONES;
						end else begin
							ctl.res_load = 1'b0;
							ctl.rd_end   = 1'b1;
							state_nxt    = S_RDWAIT;
						end
					end
					default: begin
						// Search.
						if (st.empty) begin
							ctl.res_status = ST_NOT_FOUND;
						end else begin
							ctl.res_load   = 1'b0;
							ctl.scan_start = 1'b1;
							state_nxt      = S_SCAN;
						end
					end
				endcase
			end
			S_RDWAIT: begin
				ctl.pop         = 1'b1;
				ctl.res_load    = 1'b1;
				ctl.res_removed = RM_DATA;
				state_nxt       = S_EMIT;
			end
			S_SCAN: begin
				if (st.match) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = ST_FOUND;
					ctl.res_pos    = 1'b1;
					state_nxt      = S_EMIT;
				end else if (st.last) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = ST_NOT_FOUND;
					state_nxt      = S_EMIT;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/input_restricted_deque.sv @@
// Top level of the input-restricted deque held in a linear slot array.
//
// Usage: items arrive on the request channel (command, value) and each one
// produces exactly one item on the response channel (status, removed_value,
// position). Both channels use a valid/ready handshake; an item moves at a
// rising clock edge where valid and ready are both high.
// Commands: insert at the rear, remove from the front, remove from the rear,
// and search from front to rear for the first slot holding the value.
// Path from acceptance to response valid: an insert, and any command that
// fails on an empty or full queue, passes S_EXEC and S_EMIT; a remove passes
// S_EXEC, S_RDWAIT and S_EMIT; a search passes S_EXEC, S_SCAN for each slot
// it inspects (at most DEPTH), then S_EMIT. The next request is taken once
// S_EMIT has loaded the response register and the block is back in S_IDLE.
// A search inspects one stored slot per cycle, set by the single read port.
// Reset clears the pointers, marks the queue empty and drops any pending
// response; the slot memory is not cleared, since only slots that were
// written are ever read.
// A stalled receiver does not block acceptance: the response sits in the
// output register while a new request is worked on, and only the hand-over
// of the next result waits for the register to be taken.
module input_restricted_deque import ird_pkg::*; #(
	parameter int DEPTH = 128
) (
	input logic        clk,
	input logic        arst_n,
	ird_req_if.sink    request,
	ird_rsp_if.source  response
);

	ird_ctl_t  ctl;
	ird_stat_t st;

	// Sequencer for each command.
	ird_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (response.valid),
		.out_ready (response.ready),
		.st        (st),
		.ctl       (ctl)
	);

	// Pointers, slot memory and result registers.
	ird_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.st            (st),
		.command       (request.command),
		.value         (request.value),
		.status        (response.status),
		.removed_value (response.removed_value),
		.position      (response.position)
	);

`ifndef SYNTH
	// An accepted request keeps the block busy on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("request accepted while the previous one is in progress");

	// The output register is only reloaded once the previous response has gone.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!response.valid || response.ready))
		else $error("pending response overwritten");

	// After an insert the queue can no longer be empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> !st.empty)
		else $error("queue empty after an insert");

	// A remove from an empty queue must report underflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.res_load && st.empty &&
			(st.cmd == CMD_REMOVE_FRONT || st.cmd == CMD_REMOVE_REAR))
		|-> (ctl.res_status == ST_UNDERFLOW))
		else $error("remove from empty queue without underflow");
`endif

endmodule
